// ===== hw/rtl/i2crm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types, codes and phase tables for the I2C register master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_RECOV = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NACK = 2'd1,
        STATUS_ZLEN = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_W_START  = 5'd1,
        PH_W_ADDR   = 5'd2,
        PH_W_ACK0   = 5'd3,
        PH_W_REG    = 5'd4,
        PH_W_ACK1   = 5'd5,
        PH_W_DATA   = 5'd6,
        PH_W_ACK2   = 5'd7,
        PH_W_STOP   = 5'd8,
        PH_R_START  = 5'd9,
        PH_R_ADDR   = 5'd10,
        PH_R_ACK0   = 5'd11,
        PH_R_REG    = 5'd12,
        PH_R_ACK1   = 5'd13,
        PH_R_RSTART = 5'd14,
        PH_R_ADDRR  = 5'd15,
        PH_R_ACK2   = 5'd16,
        PH_R_RECV   = 5'd17,
        PH_R_SACK   = 5'd18,
        PH_R_STOP   = 5'd19,
        PH_V_RECOV  = 5'd20,
        PH_V_STOP   = 5'd21
    } t_phase;

    typedef enum logic [2:0] {
        PR_IDLE  = 3'd0,
        PR_START = 3'd1,
        PR_SEND  = 3'd2,
        PR_ACKR  = 3'd3,
        PR_RECV  = 3'd4,
        PR_SACK  = 3'd5,
        PR_STOP  = 3'd6,
        PR_RECOV = 3'd7
    } t_proc;

    // byte source of a send phase
    typedef enum logic [1:0] {
        SRC_ADDR_W = 2'd0,
        SRC_REG    = 2'd1,
        SRC_DATA   = 2'd2,
        SRC_ADDR_R = 2'd3
    } t_src;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] dev_addr;
        logic [7:0] reg_index;
        logic [7:0] wr_data;
        logic [7:0] read_len;
        logic       sda_in;
        logic       zlen_rej;   // read of zero bytes, classified up front
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       rd_last;
        logic       done_res;
        t_status    status;
    } t_result;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd100;

    function automatic t_proc proc_of(input t_phase p);
        t_proc r;
        case (p)
            PH_W_START, PH_R_START, PH_R_RSTART:               r = PR_START;
            PH_W_ADDR, PH_W_REG, PH_W_DATA,
            PH_R_ADDR, PH_R_REG, PH_R_ADDRR:                    r = PR_SEND;
            PH_W_ACK0, PH_W_ACK1, PH_W_ACK2,
            PH_R_ACK0, PH_R_ACK1, PH_R_ACK2:                    r = PR_ACKR;
            PH_R_RECV:                                          r = PR_RECV;
            PH_R_SACK:                                          r = PR_SACK;
            PH_W_STOP, PH_R_STOP, PH_V_STOP:                    r = PR_STOP;
            PH_V_RECOV:                                         r = PR_RECOV;
            default:                                            r = PR_IDLE;
        endcase
        return r;
    endfunction

    function automatic t_src src_of(input t_phase p);
        t_src r;
        case (p)
            PH_W_REG, PH_R_REG: r = SRC_REG;
            PH_W_DATA:          r = SRC_DATA;
            PH_R_ADDRR:         r = SRC_ADDR_R;
            default:            r = SRC_ADDR_W;
        endcase
        return r;
    endfunction

    function automatic t_phase first_phase(input t_kind k);
        t_phase r;
        case (k)
            KIND_WRITE: r = PH_W_START;
            KIND_READ:  r = PH_R_START;
            KIND_RECOV: r = PH_V_RECOV;
            default:    r = PH_IDLE;
        endcase
        return r;
    endfunction

    function automatic t_phase stop_phase(input t_kind k);
        t_phase r;
        case (k)
            KIND_WRITE: r = PH_W_STOP;
            KIND_READ:  r = PH_R_STOP;
            default:    r = PH_V_STOP;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/i2c_register_master_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master_unit
// I2C master for register write, register read and bus recovery.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer (i_valid / o_stall) is one bus tick: a command field
//   set plus the sampled SDA level. Each tick gives exactly one output
//   transfer (o_valid / i_stall) with the SCL/SDA drive, busy, read byte and
//   done/status for that tick. A command is taken only while idle.
//   A tick waits in the two-entry input queue; its result is registered in
//   the output register at the edge that pops it from the queue.
//   Throughput: one tick per cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds its transfer, the
//   queue fills and o_stall rises once both entries are taken.
//   half_period is written over the cfg channel (valid/ready, always ready);
//   the user writes it only while no transaction runs, which the block itself
//   does not enforce; a write of zero counts as one.
//   Reset (synchronous, active low): queue empty, sequencer idle, both
//   lines released, half_period = 100.
// ----------------------------------------------------------------------------
module i2c_register_master_unit #(
    parameter int SEGMENT_COUNT_WIDTH = 16,
    parameter int RECOVERY_CLOCKS     = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_dev_addr,
    input  logic [7:0]  i_reg_index,
    input  logic [7:0]  i_wr_data,
    input  logic [7:0]  i_read_len,
    input  logic        i_sda_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_rd_valid,
    output logic [7:0]  o_rd_data,
    output logic        o_rd_last,
    output logic        o_done_res,
    output logic [1:0]  o_status
);
    import i2crm_pkg::*;

    logic [15:0] r_half_period;
    logic        w_q_valid, w_q_pop;
    t_item       w_q_item;
    t_result     w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half_period <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
        end
    end

    i2crm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_dev_addr  (i_dev_addr),
        .i_reg_index (i_reg_index),
        .i_wr_data   (i_wr_data),
        .i_read_len  (i_read_len),
        .i_sda_in    (i_sda_in),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_q_pop     (w_q_pop)
    );

    i2crm_engine #(
        .SEGMENT_COUNT_WIDTH (SEGMENT_COUNT_WIDTH),
        .RECOVERY_CLOCKS     (RECOVERY_CLOCKS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_period (r_half_period),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (w_res)
    );

    assign o_scl_out  = w_res.scl_out;
    assign o_sda_out  = w_res.sda_out;
    assign o_busy_res = w_res.busy_res;
    assign o_rd_valid = w_res.rd_valid;
    assign o_rd_data  = w_res.rd_data;
    assign o_rd_last  = w_res.rd_last;
    assign o_done_res = w_res.done_res;
    assign o_status   = w_res.status;

endmodule

// ===== hw/rtl/i2crm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_front
// Accepts input ticks, flags zero-length reads and queues them (two entries).
// ----------------------------------------------------------------------------
module i2crm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [6:0]         i_dev_addr,
    input  logic [7:0]         i_reg_index,
    input  logic [7:0]         i_wr_data,
    input  logic [7:0]         i_read_len,
    input  logic               i_sda_in,
    output logic               o_q_valid,
    output i2crm_pkg::t_item   o_q_item,
    input  logic               i_q_pop
);
    import i2crm_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    t_item      w_item;
    logic       w_push, w_pop;

    always_comb begin
        w_item.kind      = t_kind'(i_kind);
        w_item.dev_addr  = i_dev_addr;
        w_item.reg_index = i_reg_index;
        w_item.wr_data   = i_wr_data;
        w_item.read_len  = i_read_len;
        w_item.sda_in    = i_sda_in;
        w_item.zlen_rej  = (t_kind'(i_kind) == KIND_READ) && (i_read_len == 8'd0);
    end

    assign o_stall   = r_count[1];
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != 2'd0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= !r_wptr;
            if (w_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== hw/rtl/i2crm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_engine
// Bus sequencer: one tick per queued item, result held in an output register.
// ----------------------------------------------------------------------------
module i2crm_engine #(
    parameter int SEGMENT_COUNT_WIDTH = 16,
    parameter int RECOVERY_CLOCKS     = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_half_period,
    input  logic               i_q_valid,
    input  i2crm_pkg::t_item   i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output i2crm_pkg::t_result o_result
);
    import i2crm_pkg::*;

    localparam int CW = SEGMENT_COUNT_WIDTH;
    localparam int LW = (CW > 16) ? CW : 16;

    t_phase          r_phase, e_phase, n_phase;
    logic [CW-1:0]   r_cnt, e_cnt, n_cnt;
    logic [1:0]      r_seg, e_seg, n_seg;
    logic [3:0]      r_bit, e_bit, n_bit;
    logic [7:0]      r_byte, e_byte, n_byte;
    logic [7:0]      r_shift, e_shift, n_shift;
    t_kind           r_kind, e_kind;
    logic [6:0]      r_dev, e_dev;
    logic [7:0]      r_reg, e_reg;
    logic [7:0]      r_data, e_data;
    logic [7:0]      r_len, e_len;
    logic            r_nack, e_nack, n_nack;
    logic            r_err, e_err, n_err;
    logic            r_scl, r_sda;
    logic            w_rej, w_busy, w_seg_end, w_last, w_take;
    logic            lv_scl, lv_sda;
    logic [LW-1:0]   w_lim, w_hpm1, w_cmask;
    t_proc           w_proc;
    t_result         w_res, r_out;
    logic            r_out_valid;

    function automatic logic [7:0] load_shift(input t_phase p, input logic [6:0] d,
                                              input logic [7:0] rg, input logic [7:0] wd,
                                              input logic [7:0] cur);
        logic [7:0] r;
        r = cur;
        if (proc_of(p) == PR_SEND) begin
            case (src_of(p))
                SRC_ADDR_W: r = {d, 1'b0};
                SRC_REG:    r = rg;
                SRC_DATA:   r = wd;
                SRC_ADDR_R: r = {d, 1'b1};
                default:    r = cur;
            endcase
        end else if (proc_of(p) == PR_RECV) begin
            r = 8'd0;
        end
        return r;
    endfunction

    assign w_take  = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop = w_take;

    // segment length limit, saturated to what the counter holds
    always_comb begin
        w_hpm1  = LW'(i_half_period - 16'd1);
        w_cmask = LW'({CW{1'b1}});
        w_lim   = (w_hpm1 > w_cmask) ? w_cmask : w_hpm1;
    end

    // command launch: the first segment is driven on the accepting tick
    always_comb begin
        e_phase = r_phase;  e_cnt  = r_cnt;   e_seg  = r_seg;  e_bit  = r_bit;
        e_byte  = r_byte;   e_shift = r_shift; e_kind = r_kind; e_dev  = r_dev;
        e_reg   = r_reg;    e_data = r_data;  e_len  = r_len;  e_nack = r_nack;
        e_err   = r_err;    w_rej  = 1'b0;
        if (r_phase == PH_IDLE && i_q_item.kind != KIND_NONE) begin
            if (i_q_item.zlen_rej) begin
                w_rej = 1'b1;
            end else begin
                e_kind  = i_q_item.kind;
                e_dev   = i_q_item.dev_addr;
                e_reg   = i_q_item.reg_index;
                e_data  = i_q_item.wr_data;
                e_len   = i_q_item.read_len;
                e_nack  = 1'b0;
                e_err   = 1'b0;
                e_byte  = 8'd0;
                e_phase = first_phase(i_q_item.kind);
                e_seg   = 2'd0;
                e_bit   = 4'd0;
                e_cnt   = '0;
                e_shift = load_shift(e_phase, i_q_item.dev_addr, i_q_item.reg_index,
                                     i_q_item.wr_data, r_shift);
            end
        end
    end

    assign w_proc    = proc_of(e_phase);
    assign w_busy    = (e_phase != PH_IDLE);
    assign w_seg_end = w_busy && (LW'(e_cnt) >= w_lim);
    assign w_last    = ({1'b0, e_byte} + 9'd1) >= {1'b0, e_len};

    // line levels and result fields
    always_comb begin
        lv_scl = r_scl;
        lv_sda = r_sda;
        case (w_proc)
            PR_START: begin
                lv_scl = (e_seg < 2'd2);
                lv_sda = (e_seg == 2'd0);
            end
            PR_SEND: begin
                lv_scl = (e_seg == 2'd1);
                lv_sda = e_shift[7];
            end
            PR_ACKR: begin
                lv_scl = (e_seg == 2'd1);
                lv_sda = 1'b1;
            end
            PR_RECV: begin
                lv_scl = !e_bit[3] && (e_seg == 2'd1);
                lv_sda = 1'b1;
            end
            PR_SACK: begin
                lv_scl = (e_seg == 2'd1);
                lv_sda = w_last;
            end
            PR_STOP: begin
                lv_scl = (e_seg != 2'd0);
                lv_sda = (e_seg == 2'd2);
            end
            PR_RECOV: begin
                lv_scl = (e_seg == 2'd0);
                lv_sda = 1'b1;
            end
            default: ;
        endcase
        w_res.scl_out  = lv_scl;
        w_res.sda_out  = lv_sda;
        w_res.busy_res = w_busy;
        w_res.rd_valid = w_seg_end && (w_proc == PR_RECV) && e_bit[3];
        w_res.rd_data  = w_res.rd_valid ? e_shift : 8'd0;
        w_res.rd_last  = w_res.rd_valid && w_last;
        w_res.done_res = w_rej || (w_seg_end && (w_proc == PR_STOP) && (e_seg == 2'd2));
        if (w_rej)                         w_res.status = STATUS_ZLEN;
        else if (w_res.done_res && e_err)  w_res.status = STATUS_NACK;
        else                               w_res.status = STATUS_OK;
    end

    // next state at segment ends
    always_comb begin
        logic ent;
        ent     = 1'b0;
        n_phase = e_phase; n_cnt = e_cnt; n_seg = e_seg; n_bit = e_bit;
        n_byte  = e_byte;  n_shift = e_shift; n_nack = e_nack; n_err = e_err;
        if (w_busy) begin
            if (w_seg_end) begin
                n_cnt = '0;
                case (w_proc)
                    PR_START: begin
                        if (e_seg == 2'd2) begin
                            ent = 1'b1; n_phase = t_phase'(e_phase + 5'd1);
                        end else n_seg = e_seg + 2'd1;
                    end
                    PR_SEND: begin
                        if (e_seg == 2'd2) begin
                            n_seg   = 2'd0;
                            n_shift = {e_shift[6:0], 1'b0};
                            n_bit   = e_bit + 4'd1;
                            if (e_bit == 4'd7) begin
                                ent = 1'b1; n_phase = t_phase'(e_phase + 5'd1);
                            end
                        end else n_seg = e_seg + 2'd1;
                    end
                    PR_ACKR: begin
                        if (e_seg == 2'd1) n_nack = i_q_item.sda_in;
                        if (e_seg == 2'd2) begin
                            ent = 1'b1;
                            if (e_nack) begin
                                n_err = 1'b1; n_phase = stop_phase(e_kind);
                            end else n_phase = t_phase'(e_phase + 5'd1);
                        end else n_seg = e_seg + 2'd1;
                    end
                    PR_RECV: begin
                        if (!e_bit[3]) begin
                            if (e_seg == 2'd1) begin
                                n_shift = {e_shift[6:0], i_q_item.sda_in};
                                n_seg   = 2'd0;
                                n_bit   = e_bit + 4'd1;
                            end else n_seg = 2'd1;
                        end else begin
                            ent = 1'b1; n_phase = PH_R_SACK;
                        end
                    end
                    PR_SACK: begin
                        if (e_seg == 2'd2) begin
                            ent    = 1'b1;
                            n_byte = e_byte + 8'd1;
                            n_phase = (n_byte < e_len) ? PH_R_RECV : PH_R_STOP;
                        end else n_seg = e_seg + 2'd1;
                    end
                    PR_STOP: begin
                        if (e_seg == 2'd2) begin
                            ent = 1'b1; n_phase = PH_IDLE;
                        end else n_seg = e_seg + 2'd1;
                    end
                    PR_RECOV: begin
                        if (e_seg == 2'd0) n_seg = 2'd1;
                        else begin
                            n_seg  = 2'd0;
                            n_byte = e_byte + 8'd1;
                            if (n_byte >= 8'(RECOVERY_CLOCKS)) begin
                                ent = 1'b1; n_phase = stop_phase(e_kind);
                            end
                        end
                    end
                    default: begin
                        ent = 1'b1; n_phase = PH_IDLE;
                    end
                endcase
                if (ent) begin
                    n_seg   = 2'd0;
                    n_bit   = 4'd0;
                    n_shift = load_shift(n_phase, e_dev, e_reg, e_data, n_shift);
                end
            end else begin
                n_cnt = e_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;  r_cnt  <= '0;    r_seg  <= 2'd0;  r_bit <= 4'd0;
            r_byte  <= 8'd0;     r_shift <= 8'd0; r_kind <= KIND_NONE;
            r_dev   <= 7'd0;     r_reg  <= 8'd0;  r_data <= 8'd0;  r_len <= 8'd0;
            r_nack  <= 1'b0;     r_err  <= 1'b0;  r_scl  <= 1'b1;  r_sda <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase <= n_phase; r_cnt <= n_cnt; r_seg <= n_seg; r_bit <= n_bit;
                r_byte  <= n_byte;  r_shift <= n_shift; r_kind <= e_kind;
                r_dev   <= e_dev;   r_reg <= e_reg; r_data <= e_data; r_len <= e_len;
                r_nack  <= n_nack;  r_err <= n_err; r_scl <= lv_scl; r_sda <= lv_sda;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_out <= w_res;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/i2crm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_checker
// Port-level checks on the result stream of the I2C register master.
// ----------------------------------------------------------------------------
module i2crm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_busy_res,
    input logic       o_rd_valid,
    input logic [7:0] o_rd_data,
    input logic       o_rd_last,
    input logic       o_done_res,
    input logic [1:0] o_status
);
    import i2crm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rd_data) && $stable(o_status))
        else $error("stalled transfer changed");

    a_rd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rd_valid |-> o_rd_data == 8'd0 && !o_rd_last)
        else $error("read fields set without a byte");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_status == STATUS_OK)
        else $error("status set without done");

    a_zlen_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res && o_status == STATUS_ZLEN |-> !o_busy_res && !o_rd_valid)
        else $error("zero-length reject while busy");

endmodule

bind i2c_register_master_unit i2crm_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_busy_res (o_busy_res),
    .o_rd_valid (o_rd_valid),
    .o_rd_data  (o_rd_data),
    .o_rd_last  (o_rd_last),
    .o_done_res (o_done_res),
    .o_status   (o_status)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for i2c_register_master_unit. Every bus tick is one input transfer and
// gives one output transfer. A tick-accurate bus sequencer model in the bench
// predicts SCL/SDA drive, busy, read bytes and done/status for each tick.
// A directed table comes first, then random transactions under several
// half_period settings, with sender gaps and receiver stalls throughout.
// ----------------------------------------------------------------------------
module tb_top;
    import i2crm_pkg::*;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] dev;
        logic [7:0] rg;
        logic [7:0] dat;
        logic [7:0] len;
        logic       sda;
    } t_tick;

    typedef struct packed {
        bit          cfg_wr;
        logic [15:0] cfg_val;
        t_kind       kind;
        logic [6:0]  dev;
        logic [7:0]  rg;
        logic [7:0]  dat;
        logic [7:0]  len;
        t_phase      nack_ph;
        bit          noise;
        bit          chk;
        t_result     ex;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [6:0]  i_dev_addr;
    logic [7:0]  i_reg_index;
    logic [7:0]  i_wr_data;
    logic [7:0]  i_read_len;
    logic        i_sda_in;
    logic        o_valid;
    logic        i_stall;
    logic        o_scl_out;
    logic        o_sda_out;
    logic        o_busy_res;
    logic        o_rd_valid;
    logic [7:0]  o_rd_data;
    logic        o_rd_last;
    logic        o_done_res;
    logic [1:0]  o_status;

    i2c_register_master_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_dev_addr(i_dev_addr), .i_reg_index(i_reg_index),
        .i_wr_data(i_wr_data), .i_read_len(i_read_len), .i_sda_in(i_sda_in),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_scl_out(o_scl_out), .o_sda_out(o_sda_out), .o_busy_res(o_busy_res),
        .o_rd_valid(o_rd_valid), .o_rd_data(o_rd_data), .o_rd_last(o_rd_last),
        .o_done_res(o_done_res), .o_status(o_status)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- bus sequencer model ----------------
    t_phase      ph;
    logic [15:0] seg_cnt;
    logic [1:0]  seg;
    logic [3:0]  bit_cnt;
    logic [7:0]  byte_cnt;
    logic [7:0]  shreg;
    t_kind       cmd_kind;
    logic [6:0]  cmd_dev;
    logic [7:0]  cmd_reg, cmd_dat, cmd_len;
    bit          scl_lvl, sda_lvl, nack_seen, err_seen;
    logic [15:0] half_per;

    t_result     bus_expect[$];
    int          n_err, n_ticks, n_bytes, n_done, n_nack;
    int          burst_left;

    function automatic t_proc role(input t_phase p);
        case (p)
            PH_W_START, PH_R_START, PH_R_RSTART: return PR_START;
            PH_W_ADDR, PH_W_REG, PH_W_DATA,
            PH_R_ADDR, PH_R_REG, PH_R_ADDRR:     return PR_SEND;
            PH_W_ACK0, PH_W_ACK1, PH_W_ACK2,
            PH_R_ACK0, PH_R_ACK1, PH_R_ACK2:     return PR_ACKR;
            PH_R_RECV:                           return PR_RECV;
            PH_R_SACK:                           return PR_SACK;
            PH_W_STOP, PH_R_STOP, PH_V_STOP:     return PR_STOP;
            PH_V_RECOV:                          return PR_RECOV;
            default:                             return PR_IDLE;
        endcase
    endfunction

    function automatic bit last_byte();
        return ({1'b0, byte_cnt} + 9'd1) >= {1'b0, cmd_len};
    endfunction

    function automatic t_phase stop_of();
        case (cmd_kind)
            KIND_WRITE: return PH_W_STOP;
            KIND_READ:  return PH_R_STOP;
            default:    return PH_V_STOP;
        endcase
    endfunction

    task automatic enter(input t_phase p);
        ph = p;
        seg = 2'd0;
        bit_cnt = 4'd0;
        seg_cnt = 16'd0;
        if (role(p) == PR_SEND) begin
            case (p)
                PH_W_REG, PH_R_REG: shreg = cmd_reg;
                PH_W_DATA:          shreg = cmd_dat;
                PH_R_ADDRR:         shreg = {cmd_dev, 1'b1};
                default:            shreg = {cmd_dev, 1'b0};
            endcase
        end else if (role(p) == PR_RECV) begin
            shreg = 8'd0;
        end
    endtask

    task automatic end_segment(input logic sda, inout t_result r);
        case (role(ph))
            PR_START: if (seg == 2'd2) enter(t_phase'(ph + 5'd1)); else seg++;
            PR_SEND: begin
                if (seg == 2'd2) begin
                    seg = 2'd0;
                    shreg = shreg << 1;
                    bit_cnt++;
                    if (bit_cnt == 4'd8) enter(t_phase'(ph + 5'd1));
                end else seg++;
            end
            PR_ACKR: begin
                if (seg == 2'd1) nack_seen = sda;
                if (seg == 2'd2) begin
                    if (nack_seen) begin
                        err_seen = 1'b1;
                        enter(stop_of());
                    end else enter(t_phase'(ph + 5'd1));
                end else seg++;
            end
            PR_RECV: begin
                if (bit_cnt < 4'd8) begin
                    if (seg == 2'd1) begin
                        shreg = {shreg[6:0], sda};
                        seg = 2'd0;
                        bit_cnt++;
                    end else seg = 2'd1;
                end else begin
                    r.rd_valid = 1'b1;
                    r.rd_data = shreg;
                    r.rd_last = last_byte();
                    enter(t_phase'(ph + 5'd1));
                end
            end
            PR_SACK: begin
                if (seg == 2'd2) begin
                    byte_cnt++;
                    if (byte_cnt < cmd_len) enter(PH_R_RECV);
                    else enter(t_phase'(ph + 5'd1));
                end else seg++;
            end
            PR_STOP: begin
                if (seg == 2'd2) begin
                    r.done_res = 1'b1;
                    r.status = err_seen ? STATUS_NACK : STATUS_OK;
                    enter(PH_IDLE);
                end else seg++;
            end
            PR_RECOV: begin
                if (seg == 2'd0) seg = 2'd1;
                else begin
                    seg = 2'd0;
                    byte_cnt++;
                    if (byte_cnt >= 8'd9) enter(stop_of());
                end
            end
            default: enter(PH_IDLE);
        endcase
    endtask

    task automatic predict_tick(input t_tick t, output t_result r);
        r = '0;
        if (ph == PH_IDLE && t.kind != KIND_NONE) begin
            if (t.kind == KIND_READ && t.len == 8'd0) begin
                r.done_res = 1'b1;
                r.status = STATUS_ZLEN;
            end else begin
                cmd_kind = t.kind;
                cmd_dev = t.dev;
                cmd_reg = t.rg;
                cmd_dat = t.dat;
                cmd_len = t.len;
                nack_seen = 1'b0;
                err_seen = 1'b0;
                byte_cnt = 8'd0;
                case (t.kind)
                    KIND_WRITE: enter(PH_W_START);
                    KIND_READ:  enter(PH_R_START);
                    default:    enter(PH_V_RECOV);
                endcase
            end
        end
        if (ph != PH_IDLE) begin
            r.busy_res = 1'b1;
            case (role(ph))
                PR_START: begin scl_lvl = seg < 2'd2; sda_lvl = seg == 2'd0; end
                PR_SEND:  begin scl_lvl = seg == 2'd1; sda_lvl = shreg[7]; end
                PR_ACKR:  begin scl_lvl = seg == 2'd1; sda_lvl = 1'b1; end
                PR_RECV:  begin scl_lvl = bit_cnt < 4'd8 && seg == 2'd1; sda_lvl = 1'b1; end
                PR_SACK:  begin scl_lvl = seg == 2'd1; sda_lvl = last_byte(); end
                PR_STOP:  begin scl_lvl = seg != 2'd0; sda_lvl = seg == 2'd2; end
                PR_RECOV: begin scl_lvl = seg == 2'd0; sda_lvl = 1'b1; end
                default: ;
            endcase
            if (seg_cnt >= half_per - 16'd1) begin
                seg_cnt = 16'd0;
                end_segment(t.sda, r);
            end else seg_cnt++;
        end
        r.scl_out = scl_lvl;
        r.sda_out = sda_lvl;
    endtask

    // ---------------- sender ----------------
    task automatic put_tick(input t_tick t, input bit chk, input t_result ex);
        t_result pr;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_kind <= t.kind;
        i_dev_addr <= t.dev;
        i_reg_index <= t.rg;
        i_wr_data <= t.dat;
        i_read_len <= t.len;
        i_sda_in <= t.sda;
        do @(posedge i_clk); while (o_stall);
        predict_tick(t, pr);
        bus_expect.push_back(chk ? ex : pr);
        n_ticks++;
    endtask

    // slave side: ACK unless this ack phase is the one to NACK or noise is set; data is random
    function automatic logic slave_sda(input t_phase nack_ph, input bit noise);
        if (!noise && role(ph) == PR_ACKR) return ph == nack_ph;
        return 1'($urandom);
    endfunction

    task automatic run_txn(input t_row rw);
        t_tick       t;
        logic [63:0] rnd;
        t.kind = rw.kind;
        t.dev = rw.dev;
        t.rg = rw.rg;
        t.dat = rw.dat;
        t.len = rw.len;
        t.sda = slave_sda(rw.nack_ph, rw.noise);
        put_tick(t, rw.chk, rw.ex);
        // commands arriving while busy must be ignored, so fill them at random
        while (ph != PH_IDLE) begin
            rnd = {$urandom, $urandom};
            t = rnd[$bits(t_tick)-1:0];
            t.sda = slave_sda(rw.nack_ph, rw.noise);
            put_tick(t, 1'b0, '0);
        end
    endtask

    task automatic write_half_period(input logic [15:0] v);
        i_valid <= 1'b0;
        while (bus_expect.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        half_per = (v == 16'd0) ? 16'd1 : v;
    endtask

    function automatic t_row mk(input t_kind k, input logic [6:0] d, input logic [7:0] rg,
                                input logic [7:0] dt, input logic [7:0] ln,
                                input t_phase np, input bit nz);
        t_row r;
        r = '0;
        r.kind = k;
        r.dev = d;
        r.rg = rg;
        r.dat = dt;
        r.len = ln;
        r.nack_ph = np;
        r.noise = nz;
        return r;
    endfunction

    // ---------------- receiver and checker ----------------
    int stall_run;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run == 0) begin
            i_stall <= ~i_stall;
            stall_run <= i_stall ? $urandom_range(0, 60) : $urandom_range(0, 5);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    task automatic cmp(input string name, input int e, input int a);
        if (e != a) begin
            $error("%s mismatch: expected %0d, got %0d", name, e, a);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (bus_expect.size() == 0) begin
                $error("output transfer with nothing expected");
                n_err++;
            end else begin
                e = bus_expect.pop_front();
                cmp("scl_out", e.scl_out, o_scl_out);
                cmp("sda_out", e.sda_out, o_sda_out);
                cmp("busy_res", e.busy_res, o_busy_res);
                cmp("rd_valid", e.rd_valid, o_rd_valid);
                cmp("rd_data", e.rd_data, o_rd_data);
                cmp("rd_last", e.rd_last, o_rd_last);
                cmp("done_res", e.done_res, o_done_res);
                cmp("status", e.status, o_status);
                if (e.rd_valid) n_bytes++;
                if (e.done_res) n_done++;
                if (e.done_res && e.status == STATUS_NACK) n_nack++;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- stimulus ----------------
    initial begin
        t_row        tab[$];
        t_row        rw;
        t_result     idle_ex, zlen_ex;
        logic [15:0] hp_list[3];
        int          p, n, wait_cnt;

        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 16'd0;
        i_valid <= 1'b0;
        i_kind <= KIND_NONE;
        i_dev_addr <= '0;
        i_reg_index <= '0;
        i_wr_data <= '0;
        i_read_len <= '0;
        i_sda_in <= 1'b1;
        n_err = 0; n_ticks = 0; n_bytes = 0; n_done = 0; n_nack = 0;
        burst_left = 10;
        ph = PH_IDLE; seg_cnt = '0; seg = '0; bit_cnt = '0; byte_cnt = '0; shreg = '0;
        cmd_kind = KIND_NONE; cmd_dev = '0; cmd_reg = '0; cmd_dat = '0; cmd_len = '0;
        scl_lvl = 1'b1; sda_lvl = 1'b1; nack_seen = 1'b0; err_seen = 1'b0;
        half_per = HALF_PERIOD_RST;

        idle_ex = '0;
        idle_ex.scl_out = 1'b1;
        idle_ex.sda_out = 1'b1;
        zlen_ex = idle_ex;
        zlen_ex.done_res = 1'b1;
        zlen_ex.status = STATUS_ZLEN;

        rw = mk(KIND_NONE, '0, '0, '0, '0, PH_IDLE, 1'b0);
        rw.chk = 1'b1; rw.ex = idle_ex;
        tab.push_back(rw);
        rw = mk(KIND_READ, 7'h7f, 8'hff, 8'hff, 8'h00, PH_IDLE, 1'b0);
        rw.chk = 1'b1; rw.ex = zlen_ex;
        tab.push_back(rw);
        // zero setting runs as one tick per segment
        rw = mk(KIND_WRITE, 7'h7f, 8'hff, 8'hff, 8'hff, PH_IDLE, 1'b0);
        rw.cfg_wr = 1'b1; rw.cfg_val = 16'd0;
        tab.push_back(rw);
        tab.push_back(mk(KIND_WRITE, 7'h55, 8'haa, 8'h5a, 8'h00, PH_W_ACK1, 1'b0));
        tab.push_back(mk(KIND_READ, 7'h00, 8'h00, 8'hff, 8'd2, PH_IDLE, 1'b0));
        tab.push_back(mk(KIND_READ, 7'h12, 8'h34, 8'h00, 8'd3, PH_R_ACK0, 1'b0));
        tab.push_back(mk(KIND_RECOV, 7'h00, 8'h00, 8'h00, 8'h00, PH_IDLE, 1'b0));
        tab.push_back(mk(KIND_RECOV, 7'h7f, 8'hff, 8'hff, 8'hff, PH_IDLE, 1'b1));
        rw = mk(KIND_NONE, '0, '0, '0, '0, PH_IDLE, 1'b0);
        rw.chk = 1'b1; rw.ex = idle_ex;
        tab.push_back(rw);
        rw = mk(KIND_READ, '0, '0, '0, '0, PH_IDLE, 1'b0);
        rw.chk = 1'b1; rw.ex = zlen_ex;
        tab.push_back(rw);
        // largest setting: only ticks that finish at once, a bus transfer would take too long
        rw = mk(KIND_NONE, '0, '0, '0, '0, PH_IDLE, 1'b0);
        rw.chk = 1'b1; rw.ex = idle_ex;
        rw.cfg_wr = 1'b1; rw.cfg_val = 16'hffff;
        tab.push_back(rw);
        rw = mk(KIND_READ, 7'h7f, '0, '0, '0, PH_IDLE, 1'b0);
        rw.chk = 1'b1; rw.ex = zlen_ex;
        tab.push_back(rw);
        tab.push_back(mk(KIND_NONE, 7'h7f, 8'hff, 8'hff, 8'hff, PH_IDLE, 1'b0));
        rw = mk(KIND_RECOV, 7'h19, 8'hc4, 8'h7e, 8'h00, PH_IDLE, 1'b0);
        rw.cfg_wr = 1'b1; rw.cfg_val = 16'd2;
        tab.push_back(rw);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (tab[k]) begin
            if (tab[k].cfg_wr) write_half_period(tab[k].cfg_val);
            run_txn(tab[k]);
        end

        hp_list = '{16'd1, 16'd2, 16'd1};
        for (p = 0; p < 3; p++) begin
            write_half_period(hp_list[p]);
            if (p == 1) begin
                // hold off until the pipe is empty, then restart on an empty queue
                i_valid <= 1'b0;
                while (bus_expect.size() != 0) @(posedge i_clk);
            end
            n = n_ticks + 60;
            while (n_ticks < n) begin
                rw = mk(KIND_NONE, 7'($urandom), 8'($urandom), 8'($urandom), 8'd0,
                        PH_IDLE, $urandom_range(0, 99) < 8);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7:       rw.kind = KIND_WRITE;
                    8, 9, 10, 11, 12, 13, 14, 15: rw.kind = KIND_READ;
                    16, 17, 18:                   rw.kind = KIND_RECOV;
                    default:                      rw.kind = KIND_NONE;
                endcase
                case ($urandom_range(0, 99))
                    0, 1, 2, 3, 4: rw.len = 8'd0;
                    5, 6:          rw.len = 8'($urandom_range(5, 8));
                    default:       rw.len = 8'($urandom_range(1, 4));
                endcase
                if ($urandom_range(0, 99) < 15) begin
                    if (rw.kind == KIND_WRITE)
                        rw.nack_ph = t_phase'(PH_W_ACK0 + 5'(2 * $urandom_range(0, 2)));
                    else
                        rw.nack_ph = t_phase'(PH_R_ACK0 + 5'(2 * $urandom_range(0, 2)));
                end
                run_txn(rw);
            end
        end

        i_valid <= 1'b0;
        wait_cnt = 0;
        while (bus_expect.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (bus_expect.size() != 0) begin
            $error("%0d expected transfers never arrived", bus_expect.size());
            n_err++;
        end
        $display("run: %0d ticks, %0d transactions done (%0d NACKed), %0d bytes read",
                 n_ticks, n_done, n_nack, n_bytes);
        $display("half_period 100 (idle only), 0, 1, 2 and 65535, with stalls and gaps");
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
